// ----- rtl/ssm_pkg.sv -----
// Package for the sparse set membership block: codes, widths and defaults.
// Used by the request/result interfaces, the memories and the top level.
package ssm_pkg;

    // Fixed field widths of the request and result.
    localparam int KEY_W       = 10;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 9;

    // Default sizes of the key universe and of the member table.
    localparam int UNIVERSE_DEF = 1024;
    localparam int CAPACITY_DEF = 256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    // Sequencer states: idle, sparse table read, dense table read and write-back.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SPARSE = 2'd1,
        S_DENSE  = 2'd2
    } state_t;

endpackage

// ----- rtl/ssm_req_if.sv -----
// Request channel of the sparse set membership block: opcode and key.
// Depends on ssm_pkg for the field widths.
interface ssm_req_if;
    logic                         valid;
    logic                         ready;
    logic [ssm_pkg::OPCODE_W-1:0] opcode;
    logic [ssm_pkg::KEY_W-1:0]    key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

// ----- rtl/ssm_rsp_if.sv -----
// Result channel of the sparse set membership block: found, status, count.
// Depends on ssm_pkg for the field widths.
interface ssm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [ssm_pkg::STATUS_W-1:0]    status;
    logic [ssm_pkg::COUNT_OUT_W-1:0] member_count;

    modport source (output valid, output found, output status, output member_count,
                    input ready);
    modport sink   (input valid, input found, input status, input member_count,
                    output ready);
endinterface

// ----- rtl/sparse_set_membership.sv -----
// Top level of the sparse set membership block: sequencer, count and result register.
// Depends on ssm_pkg, ssm_req_if, ssm_rsp_if, ssm_sparse_mem and ssm_dense_mem.
//
// Usage: each request on the req channel carries an opcode (insert, search or
// delete) and a key. Exactly one result per request leaves on the rsp channel:
// found (the key was a member before the request), a status code and the member
// count after the request. Both channels move a request or result when valid and
// ready are high at a rising clock edge.
//
// Each request runs through three steps on the memory ports: the sparse table is
// read at the key, then the dense table is read at the slot found there and at the
// last member, then both tables are written back and the count is updated. The
// result is registered at write-back, and a new request is taken only once the
// sequencer is back in idle, so requests do not overlap. The chain of dependent
// reads (sparse, then dense) sets the number of steps.
//
// Reset clears the member count and the control state only. Neither table is
// cleared and no clearing pass runs: a key counts as a member only if its sparse
// entry points below the count and the dense entry there holds the key.
// A finished result waits in the output register while the receiver stalls; one
// more request is taken and runs up to write-back, where it holds until the
// waiting result has been taken.
module sparse_set_membership #(
    parameter int UNIVERSE = ssm_pkg::UNIVERSE_DEF,
    parameter int CAPACITY = ssm_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ssm_req_if.sink   req,
    ssm_rsp_if.source rsp
);

    localparam int IW     = $clog2(UNIVERSE);
    localparam int PW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int KW     = ssm_pkg::KEY_W;
    localparam int OW     = ssm_pkg::OPCODE_W;
    localparam int SW     = ssm_pkg::STATUS_W;
    localparam int OUT_CW = ssm_pkg::COUNT_OUT_W;

    ssm_pkg::state_t state_reg, state_next;

    logic [OW-1:0]     op_reg, op_next;
    logic [KW-1:0]     key_reg, key_next;
    logic              range_reg, range_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     status_reg, status_next;
    logic [OUT_CW-1:0] out_count_reg, out_count_next;

    // Memory port controls.
    logic          sp_rd_en;
    logic [IW-1:0] sp_rd_addr;
    logic [PW-1:0] sp_rd_data;
    logic          sp_wr_en;
    logic [IW-1:0] sp_wr_addr;
    logic [PW-1:0] sp_wr_data;
    logic          dn_rd_en;
    logic [PW-1:0] dn_rd_addr_a;
    logic [KW-1:0] dn_rd_data_a;
    logic [PW-1:0] dn_rd_addr_b;
    logic [KW-1:0] dn_rd_data_b;
    logic          dn_wr_en;
    logic [PW-1:0] dn_wr_addr;
    logic [KW-1:0] dn_wr_data;

    logic req_fire;
    logic load_ok;
    logic member;
    logic set_full;

    ssm_sparse_mem #(
        .DEPTH (UNIVERSE),
        .AW    (IW),
        .DW    (PW)
    ) u_sparse (
        .clk     (clk),
        .rd_en   (sp_rd_en),
        .rd_addr (sp_rd_addr),
        .rd_data (sp_rd_data),
        .wr_en   (sp_wr_en),
        .wr_addr (sp_wr_addr),
        .wr_data (sp_wr_data)
    );

    ssm_dense_mem #(
        .DEPTH (CAPACITY),
        .AW    (PW),
        .DW    (KW)
    ) u_dense (
        .clk       (clk),
        .rd_en     (dn_rd_en),
        .rd_addr_a (dn_rd_addr_a),
        .rd_data_a (dn_rd_data_a),
        .rd_addr_b (dn_rd_addr_b),
        .rd_data_b (dn_rd_data_b),
        .wr_en     (dn_wr_en),
        .wr_addr   (dn_wr_addr),
        .wr_data   (dn_wr_data)
    );

    assign req.ready = (state_reg == ssm_pkg::S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // The result register can take a new result when it is empty or being drained.
    assign load_ok = !out_valid_reg || rsp.ready;

    // Membership check: the sparse entry must point below the count and the dense
    // entry at that slot must hold the key itself.
    assign member   = (CW'(sp_rd_data) < count_reg) && (dn_rd_data_a == key_reg);
    assign set_full = (count_reg == CW'(CAPACITY));

    // The sparse table is read at the key as the request is taken.
    assign sp_rd_en   = req_fire;
    assign sp_rd_addr = IW'(req.key);

    // Slot read on port A, last member on port B, once the sparse entry is back.
    assign dn_rd_en     = (state_reg == ssm_pkg::S_SPARSE);
    assign dn_rd_addr_a = sp_rd_data;
    assign dn_rd_addr_b = PW'(count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        range_next     = range_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        status_next    = status_reg;
        out_count_next = out_count_reg;
        sp_wr_en       = 1'b0;
        sp_wr_addr     = IW'(key_reg);
        sp_wr_data     = PW'(count_reg);
        dn_wr_en       = 1'b0;
        dn_wr_addr     = PW'(count_reg);
        dn_wr_data     = key_reg;

        case (state_reg)
            ssm_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.opcode;
                    key_next   = req.key;
                    range_next = (32'(req.key) >= 32'(UNIVERSE));
                    state_next = ssm_pkg::S_SPARSE;
                end
            end

            ssm_pkg::S_SPARSE:
            begin
                state_next = ssm_pkg::S_DENSE;
            end

            ssm_pkg::S_DENSE:
            begin
                if (load_ok)
                begin
                    found_next  = 1'b0;
                    status_next = ssm_pkg::ST_OK;
                    if (range_reg)
                    begin
                        status_next = ssm_pkg::ST_RANGE;
                    end
                    else
                    begin
                        found_next = member;
                        case (op_reg)
                            ssm_pkg::OP_INSERT:
                            begin
                                if (member)
                                begin
                                    status_next = ssm_pkg::ST_DUP;
                                end
                                else if (set_full)
                                begin
                                    status_next = ssm_pkg::ST_FULL;
                                end
                                else
                                begin
                                    // Append the key at the end of the dense table.
                                    dn_wr_en   = 1'b1;
                                    sp_wr_en   = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                            end

                            ssm_pkg::OP_DELETE:
                            begin
                                if (!member)
                                begin
                                    status_next = ssm_pkg::ST_ABSENT;
                                end
                                else
                                begin
                                    // Move the last member into the freed slot.
                                    dn_wr_en   = 1'b1;
                                    dn_wr_addr = sp_rd_data;
                                    dn_wr_data = dn_rd_data_b;
                                    sp_wr_en   = 1'b1;
                                    sp_wr_addr = IW'(dn_rd_data_b);
                                    sp_wr_data = sp_rd_data;
                                    count_next = count_reg - CW'(1);
                                end
                            end

                            default:
                            begin
                                // Search and the unused opcode leave the set alone.
                            end
                        endcase
                    end
                    out_count_next = OUT_CW'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = ssm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ssm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssm_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        range_reg     <= range_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        out_count_reg <= out_count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = found_reg;
    assign rsp.status       = status_reg;
    assign rsp.member_count = out_count_reg;

    // The member count never grows past the table capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("member count above capacity");

    // The count only moves at write-back of a request.
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ssm_pkg::S_DENSE) |=> $stable(count_reg))
        else $error("member count changed outside write-back");

    // Both tables are written together, and only for an in-range key.
    a_paired_write: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_wr_en || dn_wr_en) |-> (sp_wr_en && dn_wr_en && !range_reg && load_ok))
        else $error("table write without its partner or out of range");

    // A taken request moves the sequencer to the sparse state in the next cycle.
    a_req_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ssm_pkg::S_SPARSE))
        else $error("request taken but sequencer did not start");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready && state_reg == ssm_pkg::S_DENSE)
            |=> (state_reg == ssm_pkg::S_DENSE))
        else $error("result register overwritten while stalled");

endmodule

// ----- rtl/ssm_sparse_mem.sv -----
// Sparse position table: one slot index per key, one read and one write port.
// Synchronous read with registered data; no reset, entries are validated on use.
module ssm_sparse_mem #(
    parameter int DEPTH = ssm_pkg::UNIVERSE_DEF,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ssm_dense_mem.sv -----
// Dense member table: member keys by slot, two read ports and one write port.
// Synchronous reads with registered data; only slots below the count are trusted.
module ssm_dense_mem #(
    parameter int DEPTH = ssm_pkg::CAPACITY_DEF,
    parameter int AW    = 8,
    parameter int DW    = ssm_pkg::KEY_W
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    output logic [DW-1:0] rd_data_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_b,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_a_reg;
    logic [DW-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the sparse set membership block: insert, search and delete requests.
// Depends on ssm_pkg, ssm_req_if, ssm_rsp_if and the sparse_set_membership RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int KEY_W       = ssm_pkg::KEY_W;
    localparam int OPCODE_W    = ssm_pkg::OPCODE_W;
    localparam int COUNT_OUT_W = ssm_pkg::COUNT_OUT_W;

    // The universe fills the key field, so every key value names a possible member.
    localparam int SET_UNIVERSE = ssm_pkg::UNIVERSE_DEF;
    localparam int SET_CAPACITY = ssm_pkg::CAPACITY_DEF;

    // Opcode 3 has no enum member. The block treats it as a search.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 1400;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [KEY_W-1:0]    key;
    } request_t;

    typedef struct packed {
        logic                   found;
        ssm_pkg::status_t       status;
        logic [COUNT_OUT_W-1:0] member_count;
    } outcome_t;

    logic clk;
    logic rst_n;

    ssm_req_if req ();
    ssm_rsp_if rsp ();

    sparse_set_membership #(
        .UNIVERSE (SET_UNIVERSE),
        .CAPACITY (SET_CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Requests waiting to be offered, and the outcomes predicted for accepted requests.
    request_t request_backlog[$];
    outcome_t pending_outcomes[$];

    int error_count   = 0;
    int results_seen  = 0;

    // Predictor state. It mirrors the block's sparse table, dense table and count.
    // The sparse table starts at zero here. A stale entry cannot change an answer,
    // because membership is always confirmed against the dense table and the count.
    int unsigned slot_of_key [SET_UNIVERSE];
    int unsigned member_keys [SET_CAPACITY];
    int unsigned live_count = 0;

    // Generation-time view of the set. It lets the stimulus aim at members and
    // non-members. Requests are accepted in the order they are queued, so this view
    // stays in step with the predictor.
    bit gen_is_member [SET_UNIVERSE];
    int gen_members[$];

    // Driver and receiver pacing.
    int burst_left;
    int gap_left;
    int hold_left;
    int next_hold_at;
    logic [8:0] ready_phase;

    // Computes the result of one accepted request and updates the predicted set.
    // A delete moves the last dense member into the freed slot, as the block does.
    function automatic outcome_t predict_outcome(logic [OPCODE_W-1:0] op,
                                                 logic [KEY_W-1:0] k);
        outcome_t    res;
        int unsigned slot;
        int unsigned moved;
        bit          member;
        res.found  = 1'b0;
        res.status = ssm_pkg::ST_OK;
        if (k >= SET_UNIVERSE)
        begin
            res.status = ssm_pkg::ST_RANGE;
        end
        else
        begin
            slot   = slot_of_key[k];
            member = slot < live_count && slot < SET_CAPACITY && member_keys[slot] == k;
            res.found = member;
            if (op == ssm_pkg::OP_INSERT)
            begin
                if (member)
                begin
                    res.status = ssm_pkg::ST_DUP;
                end
                else if (live_count >= SET_CAPACITY)
                begin
                    res.status = ssm_pkg::ST_FULL;
                end
                else
                begin
                    member_keys[live_count] = k;
                    slot_of_key[k] = live_count;
                    live_count++;
                end
            end
            else if (op == ssm_pkg::OP_DELETE)
            begin
                if (!member)
                begin
                    res.status = ssm_pkg::ST_ABSENT;
                end
                else
                begin
                    moved = member_keys[live_count - 1];
                    member_keys[slot] = moved;
                    if (moved < SET_UNIVERSE)
                    begin
                        slot_of_key[moved] = slot;
                    end
                    live_count--;
                end
            end
        end
        res.member_count = COUNT_OUT_W'(live_count);
        return res;
    endfunction

    // Queues one request and applies it to the generation-time view of the set.
    function void queue_request(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] k);
        request_t r;
        r.op  = op;
        r.key = k;
        request_backlog.push_back(r);
        if (k < SET_UNIVERSE)
        begin
            if (op == ssm_pkg::OP_INSERT && !gen_is_member[k]
                && gen_members.size() < SET_CAPACITY)
            begin
                gen_is_member[k] = 1'b1;
                gen_members.push_back(k);
            end
            else if (op == ssm_pkg::OP_DELETE && gen_is_member[k])
            begin
                gen_is_member[k] = 1'b0;
                foreach (gen_members[i])
                begin
                    if (gen_members[i] == k)
                    begin
                        gen_members.delete(i);
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do
        begin
            k = KEY_W'($urandom_range(0, SET_UNIVERSE - 1));
        end
        while (gen_is_member[k]);
        return k;
    endfunction

    // Returns a current member half the time, and otherwise any value of the key field.
    function automatic logic [KEY_W-1:0] member_or_any();
        if (gen_members.size() > 0 && $urandom_range(0, 1) == 1)
        begin
            return KEY_W'(gen_members[$urandom_range(0, gen_members.size() - 1)]);
        end
        return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver. A new request is presented when the current one has been taken,
    // or when none is being offered. The sender works in bursts of random length and
    // leaves random gaps between them. Some gaps are zero, so back-to-back stretches occur.
    always @(posedge clk or negedge rst_n)
    begin
        request_t next_req;
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            req.opcode <= ssm_pkg::OP_SEARCH;
            req.key    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (gap_left == 0 && request_backlog.size() > 0)
            begin
                next_req = request_backlog.pop_front();
                req.valid  <= 1'b1;
                req.opcode <= next_req.op;
                req.key    <= next_req.key;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                req.valid <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Each accepted request is run through the predictor at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && req.valid === 1'b1 && req.ready === 1'b1)
        begin
            pending_outcomes.push_back(predict_outcome(req.opcode, req.key));
        end
    end

    // Result receiver. A phase counter steps the stall pattern through always ready,
    // random stalls, alternating and sparse patterns. Twice during the run the
    // receiver holds off for a long stretch while the sender keeps offering requests.
    // This fills the output register and the request held at write-back, so the block
    // has to stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready    <= 1'b0;
            ready_phase  <= '0;
            hold_left    <= 0;
            next_hold_at <= 400;
        end
        else
        begin
            ready_phase <= ready_phase + 1'b1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (results_seen >= next_hold_at && next_hold_at < 1500)
            begin
                hold_left    <= HOLD_CYCLES;
                next_hold_at <= next_hold_at + 700;
                rsp.ready    <= 1'b0;
            end
            else
            begin
                case (ready_phase[8:6])
                    3'd0, 3'd1: rsp.ready <= 1'b1;
                    3'd2:       rsp.ready <= 1'($urandom_range(0, 1));
                    3'd3:       rsp.ready <= ready_phase[0];
                    3'd4:       rsp.ready <= (ready_phase[1:0] == 2'd0);
                    3'd5:       rsp.ready <= ($urandom_range(0, 3) != 0);
                    3'd6:       rsp.ready <= (ready_phase[2:0] < 3'd5);
                    default:    rsp.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Result monitor. Each accepted result is checked field by field against the
    // oldest predicted outcome.
    always @(posedge clk)
    begin
        outcome_t exp_out;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            results_seen <= results_seen + 1;
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: found %0d status %0d count %0d",
                       rsp.found, rsp.status, rsp.member_count);
                error_count <= error_count + 1;
            end
            else
            begin
                exp_out = pending_outcomes.pop_front();
                if (rsp.found !== exp_out.found)
                begin
                    $error("found mismatch: expected %0d, got %0d", exp_out.found, rsp.found);
                    error_count <= error_count + 1;
                end
                if (rsp.status !== exp_out.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", exp_out.status, rsp.status);
                    error_count <= error_count + 1;
                end
                if (rsp.member_count !== exp_out.member_count)
                begin
                    $error("member_count mismatch: expected %0d, got %0d",
                           exp_out.member_count, rsp.member_count);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    initial
    begin
        int mode;
        int span;
        int roll;
        int total;
        rst_n = 1'b0;

        // Directed requests. They cover the lowest and highest keys and every opcode,
        // including the unused one. They also cover duplicate inserts, absent deletes,
        // and a delete that moves the last member into the freed slot. The delete that
        // empties the set and alternating key bit patterns are included too.
        queue_request(ssm_pkg::OP_INSERT, 10'd0);
        queue_request(ssm_pkg::OP_INSERT, 10'd1023);
        queue_request(ssm_pkg::OP_INSERT, 10'd1023);
        queue_request(ssm_pkg::OP_SEARCH, 10'd0);
        queue_request(ssm_pkg::OP_SEARCH, 10'd1023);
        queue_request(ssm_pkg::OP_SEARCH, 10'd512);
        queue_request(OP_UNUSED, 10'd1023);
        queue_request(ssm_pkg::OP_INSERT, 10'd0);
        queue_request(ssm_pkg::OP_DELETE, 10'd512);
        queue_request(ssm_pkg::OP_DELETE, 10'd0);
        queue_request(ssm_pkg::OP_SEARCH, 10'd1023);
        queue_request(ssm_pkg::OP_SEARCH, 10'd0);
        queue_request(ssm_pkg::OP_DELETE, 10'd1023);
        queue_request(ssm_pkg::OP_DELETE, 10'd1023);
        queue_request(ssm_pkg::OP_SEARCH, 10'd1010);
        queue_request(OP_UNUSED, 10'd0);
        queue_request(ssm_pkg::OP_INSERT, 10'd341);
        queue_request(ssm_pkg::OP_INSERT, 10'd682);
        queue_request(ssm_pkg::OP_DELETE, 10'd341);
        queue_request(ssm_pkg::OP_SEARCH, 10'd682);
        queue_request(ssm_pkg::OP_INSERT, 10'd341);
        total = request_backlog.size() + RANDOM_REQUESTS;

        // Fill the set to capacity. Then try inserts against a full set, a duplicate
        // insert and a search.
        while (gen_members.size() < SET_CAPACITY)
        begin
            queue_request(ssm_pkg::OP_INSERT, fresh_key());
        end
        queue_request(ssm_pkg::OP_INSERT, fresh_key());
        queue_request(ssm_pkg::OP_INSERT, fresh_key());
        queue_request(ssm_pkg::OP_INSERT, KEY_W'(gen_members[0]));
        queue_request(ssm_pkg::OP_SEARCH, KEY_W'(gen_members[SET_CAPACITY - 1]));

        // Random episodes. Growing and shrinking runs with random keys take the set
        // between empty and full many times. Mixed runs and raw noise over the whole
        // request space fill out the rest.
        while (request_backlog.size() < total)
        begin
            mode = $urandom_range(0, 9);
            span = (mode == 9) ? $urandom_range(5, 20) : $urandom_range(20, 120);
            repeat (span)
            begin
                roll = $urandom_range(0, 9);
                if (mode <= 2)
                begin
                    if (roll < 8)
                    begin
                        queue_request(ssm_pkg::OP_INSERT, fresh_key());
                    end
                    else if (roll == 8 && gen_members.size() > 0)
                    begin
                        queue_request(ssm_pkg::OP_INSERT, KEY_W'(gen_members[$urandom_range(0,
                                      gen_members.size() - 1)]));
                    end
                    else
                    begin
                        queue_request(ssm_pkg::OP_SEARCH, member_or_any());
                    end
                end
                else if (mode <= 5)
                begin
                    if (roll < 7 && gen_members.size() > 0)
                    begin
                        queue_request(ssm_pkg::OP_DELETE, KEY_W'(gen_members[$urandom_range(0,
                                      gen_members.size() - 1)]));
                    end
                    else if (roll < 9)
                    begin
                        queue_request(ssm_pkg::OP_DELETE, fresh_key());
                    end
                    else
                    begin
                        queue_request(ssm_pkg::OP_SEARCH, member_or_any());
                    end
                end
                else if (mode <= 8)
                begin
                    queue_request(OPCODE_W'($urandom_range(0, 2)), member_or_any());
                end
                else
                begin
                    queue_request(OPCODE_W'($urandom_range(0, 3)),
                                  KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
                end
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to be taken and every predicted outcome to be
        // matched. Then keep the clock running so that any stray result would show.
        while (request_backlog.size() > 0 || req.valid) @(posedge clk);
        while (pending_outcomes.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_outcomes.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit. It is far beyond the slowest legal run, even with every stall.
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
